@@ rtl/wras_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the weighted random agent selector.
// No dependencies; every other rtl file imports this package.
package wras_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    // Eligible weight sum: at most MAX_ENTRIES * 65535
    localparam int SUM_W = 16 + IDX_W;

    localparam logic [10:0] LOAD_LIMIT_RST = 11'd922;

    localparam logic [1:0] FN_REGISTER   = 2'd0;
    localparam logic [1:0] FN_UNREGISTER = 2'd1;
    localparam logic [1:0] FN_SCHEDULE   = 2'd2;
    localparam logic [1:0] FN_RESERVED   = 2'd3;

    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_FULL          = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND     = 3'd2;
    localparam logic [2:0] ST_EMPTY         = 3'd3;
    localparam logic [2:0] ST_NONE_ELIGIBLE = 3'd4;
    localparam logic [2:0] ST_NONE_PICKED   = 3'd5;

    typedef struct packed {
        logic [31:0] key;
        logic [15:0] weight;
        logic [10:0] load;
        logic [31:0] tms;
        logic        ready;
    } entry_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        entry_t           wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

@@ rtl/wras_tbl.sv @@
`timescale 1ns / 1ps
// Agent table: one synchronous memory of entries, one write and one read port.
// Depends on wras_pkg for the entry and request types.
module wras_tbl import wras_pkg::*;
(
    input  logic     clk,
    input  mem_req_t req,
    output entry_t   rd_data
);

    entry_t mem [MAX_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/wras_div.sv @@
`timescale 1ns / 1ps
// Serial divider for the confidence: floor(weight * 65536 / sum), saturated.
// Depends on wras_pkg for SUM_W. One quotient bit per cycle, 16 steps.
module wras_div import wras_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      weight,
    input  logic [SUM_W-1:0] divisor,
    output logic             done,
    output logic [15:0]      quot
);

    logic             busy_reg;
    logic             done_reg;
    logic [3:0]       cnt_reg;
    logic [SUM_W-1:0] rem_reg;
    logic [15:0]      q_reg;
    logic             sat_reg;
    logic [SUM_W:0]   rem_sh;
    logic             qbit;
    logic [SUM_W-1:0] weight_ext;

    assign weight_ext = SUM_W'(weight);
    assign rem_sh     = {rem_reg, 1'b0};
    assign qbit       = (rem_sh >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                // while weight does not exceed the sum the integer part is 0 or 1; 1 or more saturates
                sat_reg  <= (weight_ext >= divisor);
                rem_reg  <= (weight_ext >= divisor) ? weight_ext - divisor : weight_ext;
                busy_reg <= 1'b1;
                cnt_reg  <= 4'd15;
                q_reg    <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= qbit ? SUM_W'(rem_sh - {1'b0, divisor}) : SUM_W'(rem_sh);
                q_reg   <= {q_reg[14:0], qbit};
                cnt_reg <= cnt_reg - 4'd1;
                if (cnt_reg == 4'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = sat_reg ? 16'hFFFF : q_reg;

endmodule

@@ rtl/weighted_random_agent_selector.sv @@
`timescale 1ns / 1ps
// Weighted random agent selector. One item at a time: each pass reads the agent table
// one entry per cycle through its single read port, a register or unregister item
// makes one pass, a schedule makes two passes (weight sum, then pick), and the
// confidence comes from a 16-step serial divider. The next item is taken while the
// previous result still waits in the output register.
module weighted_random_agent_selector import wras_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [10:0]       cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        func,
    input  logic [31:0]       agent_key,
    input  logic [15:0]       agent_weight,
    input  logic [10:0]       agent_load,
    input  logic [31:0]       agent_time_ms,
    input  logic              agent_ready,
    input  logic [15:0]       random_fraction,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic [31:0]       chosen_key,
    output logic [15:0]       confidence,
    output logic [31:0]       expected_time_ms,
    output logic [CNT_W-1:0]  ready_count,
    output logic [CNT_W-1:0]  entry_count
);

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WRITE, S_MUL, S_SCAN2, S_DIV, S_DONE
    } state_t;

    state_t            state_reg;
    logic [10:0]       load_limit_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  ready_cnt_reg;

    logic [1:0]        func_reg;
    entry_t            item_reg;
    logic [15:0]       r_reg;

    logic [CNT_W-1:0]  rd_idx_reg;
    logic              dv_reg;
    logic [IDX_W-1:0]  dix_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic              old_rdy_reg;

    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    run_reg;
    logic [SUM_W+15:0]   prod_reg;
    logic                picked_reg;
    entry_t              pick_reg;

    logic [2:0]        res_status_reg;
    logic [31:0]       res_key_reg;
    logic [15:0]       res_conf_reg;
    logic [31:0]       res_tms_reg;

    logic              out_valid_reg;
    logic [2:0]        status_reg;
    logic [31:0]       chosen_key_reg;
    logic [15:0]       confidence_reg;
    logic [31:0]       expected_time_reg;
    logic [CNT_W-1:0]  ready_count_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    mem_req_t          mem_req;
    entry_t            rd_data;
    logic              scanning;
    logic              issue;
    logic              elig;
    logic              key_hit;
    logic [SUM_W-1:0]  run_new;
    logic [SUM_W+15:0] run_scaled;
    logic              div_start;
    logic              div_done;
    logic [15:0]       div_quot;
    logic              accept;

    assign scanning   = (state_reg == S_SCAN) || (state_reg == S_SCAN2);
    assign issue      = scanning && (rd_idx_reg < used_reg);
    assign elig       = rd_data.ready && (rd_data.load < load_limit_reg);
    assign key_hit    = (rd_data.key == item_reg.key);
    assign run_new    = run_reg + SUM_W'(rd_data.weight);
    assign run_scaled = {run_new, 16'd0} - (SUM_W + 16)'(run_new);
    assign div_start  = (state_reg == S_SCAN2) && !issue && !dv_reg && picked_reg;
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;

    always_comb
    begin
        mem_req       = '0;
        mem_req.re    = issue;
        mem_req.raddr = rd_idx_reg[IDX_W-1:0];
        if (state_reg == S_WRITE)
        begin
            mem_req.we    = 1'b1;
            mem_req.waddr = slot_reg;
            mem_req.wdata = item_reg;
        end
        else if ((state_reg == S_SCAN) && (func_reg == FN_UNREGISTER) && dv_reg && found_reg)
        begin
            // shift every entry past the removed one down by one
            mem_req.we    = 1'b1;
            mem_req.waddr = dix_reg - IDX_W'(1);
            mem_req.wdata = rd_data;
        end
    end

    wras_tbl u_tbl (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    wras_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .weight  (pick_reg.weight),
        .divisor (sum_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            load_limit_reg    <= LOAD_LIMIT_RST;
            used_reg          <= '0;
            ready_cnt_reg     <= '0;
            func_reg          <= FN_REGISTER;
            item_reg          <= '0;
            r_reg             <= '0;
            rd_idx_reg        <= '0;
            dv_reg            <= 1'b0;
            dix_reg           <= '0;
            found_reg         <= 1'b0;
            slot_reg          <= '0;
            old_rdy_reg       <= 1'b0;
            sum_reg           <= '0;
            run_reg           <= '0;
            prod_reg          <= '0;
            picked_reg        <= 1'b0;
            pick_reg          <= '0;
            res_status_reg    <= ST_OK;
            res_key_reg       <= '0;
            res_conf_reg      <= '0;
            res_tms_reg       <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= ST_OK;
            chosen_key_reg    <= '0;
            confidence_reg    <= '0;
            expected_time_reg <= '0;
            ready_count_reg   <= '0;
            entry_count_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                load_limit_reg <= cfg_wdata;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // read pipeline: data for the address issued last cycle arrives now
            dv_reg  <= issue;
            dix_reg <= rd_idx_reg[IDX_W-1:0];
            if (issue)
            begin
                rd_idx_reg <= rd_idx_reg + CNT_W'(1);
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        func_reg       <= func;
                        item_reg       <= '{agent_key, agent_weight, agent_load,
                                            agent_time_ms, agent_ready};
                        r_reg          <= random_fraction;
                        rd_idx_reg     <= '0;
                        found_reg      <= 1'b0;
                        sum_reg        <= '0;
                        res_status_reg <= ST_OK;
                        res_key_reg    <= '0;
                        res_conf_reg   <= '0;
                        res_tms_reg    <= '0;
                        state_reg      <= (func == FN_RESERVED) ? S_DONE : S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    if (dv_reg)
                    begin
                        if (func_reg == FN_SCHEDULE)
                        begin
                            if (elig)
                            begin
                                sum_reg <= sum_reg + SUM_W'(rd_data.weight);
                            end
                        end
                        else if (!found_reg && key_hit)
                        begin
                            found_reg   <= 1'b1;
                            slot_reg    <= dix_reg;
                            old_rdy_reg <= rd_data.ready;
                        end
                    end
                    else if (!issue)
                    begin
                        unique case (func_reg)
                            FN_REGISTER:
                            begin
                                if (found_reg)
                                begin
                                    state_reg <= S_WRITE;
                                end
                                else if (used_reg == CNT_W'(MAX_ENTRIES))
                                begin
                                    res_status_reg <= ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    slot_reg  <= used_reg[IDX_W-1:0];
                                    state_reg <= S_WRITE;
                                end
                            end
                            FN_UNREGISTER:
                            begin
                                if (found_reg)
                                begin
                                    used_reg      <= used_reg - CNT_W'(1);
                                    ready_cnt_reg <= ready_cnt_reg - CNT_W'(old_rdy_reg);
                                end
                                else
                                begin
                                    res_status_reg <= ST_NOT_FOUND;
                                end
                                state_reg <= S_DONE;
                            end
                            FN_SCHEDULE:
                            begin
                                if (used_reg == '0)
                                begin
                                    res_status_reg <= ST_EMPTY;
                                    state_reg      <= S_DONE;
                                end
                                else if (sum_reg == '0)
                                begin
                                    res_status_reg <= ST_NONE_ELIGIBLE;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                            default:
                            begin
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end

                S_WRITE:
                begin
                    if (found_reg)
                    begin
                        ready_cnt_reg <= ready_cnt_reg - CNT_W'(old_rdy_reg)
                                         + CNT_W'(item_reg.ready);
                    end
                    else
                    begin
                        used_reg      <= used_reg + CNT_W'(1);
                        ready_cnt_reg <= ready_cnt_reg + CNT_W'(item_reg.ready);
                    end
                    state_reg <= S_DONE;
                end

                S_MUL:
                begin
                    prod_reg   <= (SUM_W + 16)'(r_reg) * (SUM_W + 16)'(sum_reg);
                    rd_idx_reg <= '0;
                    run_reg    <= '0;
                    picked_reg <= 1'b0;
                    state_reg  <= S_SCAN2;
                end

                S_SCAN2:
                begin
                    if (dv_reg)
                    begin
                        if (elig && !picked_reg)
                        begin
                            run_reg <= run_new;
                            if (prod_reg <= run_scaled)
                            begin
                                picked_reg <= 1'b1;
                                pick_reg   <= rd_data;
                            end
                        end
                    end
                    else if (!issue)
                    begin
                        if (picked_reg)
                        begin
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            res_status_reg <= ST_NONE_PICKED;
                            state_reg      <= S_DONE;
                        end
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        res_status_reg <= ST_OK;
                        res_key_reg    <= pick_reg.key;
                        res_conf_reg   <= div_quot;
                        res_tms_reg    <= pick_reg.tms;
                        state_reg      <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg     <= 1'b1;
                        status_reg        <= res_status_reg;
                        chosen_key_reg    <= res_key_reg;
                        confidence_reg    <= res_conf_reg;
                        expected_time_reg <= res_tms_reg;
                        ready_count_reg   <= ready_cnt_reg;
                        entry_count_reg   <= used_reg;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign chosen_key       = chosen_key_reg;
    assign confidence       = confidence_reg;
    assign expected_time_ms = expected_time_reg;
    assign ready_count      = ready_count_reg;
    assign entry_count      = entry_count_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table depth");

    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ready_cnt_reg <= used_reg)
        else $error("ready count above entry count");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("table read and write hit the same entry");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result issued outside the done state");
`endif

endmodule
